[src/shortest_job_first_dispatcher_assert.svh]
// Assertion macros shared by the dispatcher modules.
`ifndef SHORTEST_JOB_FIRST_DISPATCHER_ASSERT_SVH
`define SHORTEST_JOB_FIRST_DISPATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SJFD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SJFD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[src/sjfd_pkg.sv]
// Types and constants shared by the shortest-job-first dispatcher.
`timescale 1ns / 1ps
package sjfd_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 24;

    typedef enum logic {
        REQ_ADD      = 1'b0,
        REQ_DISPATCH = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_ADDED      = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t            kind;
        logic [ID_W-1:0]      id;
        logic [BURST_W-1:0]   burst;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_FIN,
        S_COMMIT
    } back_state_t;

endpackage

[src/shortest_job_first_dispatcher.sv]
// Top level of the shortest-job-first dispatcher.
//
//  Channel  Signals                                   Role
//  req      req_valid/req_ready, req_type, task_id,   add a task or dispatch the
//           burst_len                                 shortest pending task
//  rsp      rsp_valid/rsp_ready, status, picked_id,   one response per request
//           picked_burst, start_time, finish_time
//
// An add walks the valid bits for the lowest free slot; a dispatch scans the whole task
// memory with one compare per cycle, then passes through S_FIN and S_COMMIT. Full and
// empty answer straight from the idle state, with no walk or scan. Reset clears the
// valid bits, the count and the running clock at once. A two-entry queue lets
// requests arrive while the engine is busy, and the response register lets the engine
// start the next request while a response still waits to be taken.
`timescale 1ns / 1ps
module shortest_job_first_dispatcher
    import sjfd_pkg::*;
#(
    parameter int MAX_TASKS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_type,
    input  logic [ID_W-1:0]      task_id,
    input  logic [BURST_W-1:0]   burst_len,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      picked_id,
    output logic [BURST_W-1:0]   picked_burst,
    output logic [TIME_W-1:0]    start_time,
    output logic [TIME_W-1:0]    finish_time
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    sjfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .task_id   (task_id),
        .burst_len (burst_len),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    sjfd_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .picked_id    (picked_id),
        .picked_burst (picked_burst),
        .start_time   (start_time),
        .finish_time  (finish_time)
    );

endmodule

[src/sjfd_front.sv]
// Request front end: classifies requests and holds them in a two-entry queue.
`timescale 1ns / 1ps
`include "shortest_job_first_dispatcher_assert.svh"
module sjfd_front
    import sjfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_type,
    input  logic [ID_W-1:0]      task_id,
    input  logic [BURST_W-1:0]   burst_len,
    output logic                 q_valid,
    output cmd_t                 q_cmd,
    input  logic                 q_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       in_cmd;

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_cmd     = slot_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;

    always_comb
    begin
        in_cmd.kind  = req_kind_t'(req_type);
        in_cmd.id    = task_id;
        in_cmd.burst = burst_len;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    `SJFD_ASSERT_NOW(a_pop_needs_entry, clk, rst_n, q_pop, q_valid)
    `SJFD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 2'd2)
    `SJFD_ASSERT_NOW(a_ptr_match, clk, rst_n, (cnt_reg == 2'd0) || (cnt_reg == 2'd2), wr_ptr_reg == rd_ptr_reg)

endmodule

[src/sjfd_back.sv]
// Task table and scheduler engine: add, scan for the shortest burst, dispatch.
`timescale 1ns / 1ps
`include "shortest_job_first_dispatcher_assert.svh"
module sjfd_back
    import sjfd_pkg::*;
#(
    parameter int MAX_TASKS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      picked_id,
    output logic [BURST_W-1:0]   picked_burst,
    output logic [TIME_W-1:0]    start_time,
    output logic [TIME_W-1:0]    finish_time
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

    logic [ID_W-1:0]     id_mem    [MAX_TASKS];
    logic [BURST_W-1:0]  burst_mem [MAX_TASKS];

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [IW-1:0]       scan_reg;
    logic [IW-1:0]       scan_next;
    logic [MAX_TASKS-1:0] valid_reg;
    logic [MAX_TASKS-1:0] valid_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [TIME_W-1:0]   clock_reg;
    logic [TIME_W-1:0]   clock_next;

    logic [ID_W-1:0]     rd_id_reg;
    logic [BURST_W-1:0]  rd_burst_reg;
    logic                cmp_live_reg;
    logic                cmp_vld_reg;
    logic [IW-1:0]       cmp_idx_reg;
    logic                found_reg;
    logic [IW-1:0]       best_idx_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic [BURST_W-1:0]  best_burst_reg;

    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    logic [ID_W-1:0]     rsp_id_reg;
    logic [BURST_W-1:0]  rsp_burst_reg;
    logic [TIME_W-1:0]   rsp_start_reg;
    logic [TIME_W-1:0]   rsp_finish_reg;

    logic                res_free;
    logic                mem_we;
    logic                emit;
    status_t             emit_status;
    logic [ID_W-1:0]     emit_id;
    logic [BURST_W-1:0]  emit_burst;
    logic [TIME_W-1:0]   emit_start;
    logic [TIME_W-1:0]   emit_finish;
    logic [TIME_W:0]     finish_sum;
    logic [TIME_W-1:0]   finish_sat;
    logic                better;

    assign res_free   = !rsp_valid_reg || rsp_ready;
    assign finish_sum = {1'b0, clock_reg} + {{(TIME_W + 1 - BURST_W){1'b0}}, best_burst_reg};
    assign finish_sat = finish_sum[TIME_W] ? {TIME_W{1'b1}} : finish_sum[TIME_W-1:0];
    assign better     = cmp_live_reg && cmp_vld_reg &&
                        (!found_reg || (rd_burst_reg < best_burst_reg) ||
                         ((rd_burst_reg == best_burst_reg) && (rd_id_reg < best_id_reg)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if ((q_cmd.kind == REQ_ADD) && (count_reg != FULL_CNT))
                    begin
                        state_next = S_FREE;
                    end
                    else if ((q_cmd.kind == REQ_DISPATCH) && (count_reg != '0))
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_FREE:
            begin
                if (!valid_reg[scan_reg] && res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        emit_status = ST_ADDED;
        emit_id     = '0;
        emit_burst  = '0;
        emit_start  = '0;
        emit_finish = '0;
        scan_next   = scan_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        clock_next  = clock_reg;
        case (state_reg)
            S_IDLE:
            begin
                scan_next = '0;
                if (q_valid && res_free)
                begin
                    if ((q_cmd.kind == REQ_ADD) && (count_reg == FULL_CNT))
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FULL;
                        q_pop       = 1'b1;
                    end
                    else if ((q_cmd.kind == REQ_DISPATCH) && (count_reg == '0))
                    begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY;
                        q_pop       = 1'b1;
                    end
                end
            end
            S_FREE:
            begin
                if (valid_reg[scan_reg])
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else if (res_free)
                begin
                    mem_we               = 1'b1;
                    valid_next[scan_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    emit                 = 1'b1;
                    emit_status          = ST_ADDED;
                    q_pop                = 1'b1;
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
            end
            S_FIN:
            begin
                scan_next = scan_reg;
            end
            S_COMMIT:
            begin
                if (res_free)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    count_next               = count_reg - 1'b1;
                    clock_next               = finish_sat;
                    emit                     = 1'b1;
                    emit_status              = ST_DISPATCHED;
                    emit_id                  = best_id_reg;
                    emit_burst               = best_burst_reg;
                    emit_start               = clock_reg;
                    emit_finish              = finish_sat;
                    q_pop                    = 1'b1;
                end
            end
            default:
            begin
                scan_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            clock_reg     <= '0;
            cmp_live_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            clock_reg    <= clock_next;
            cmp_live_reg <= (state_reg == S_SCAN);
            if (state_reg == S_IDLE)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[scan_reg]    <= q_cmd.id;
            burst_mem[scan_reg] <= q_cmd.burst;
        end
        rd_id_reg    <= id_mem[scan_reg];
        rd_burst_reg <= burst_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        cmp_vld_reg <= valid_reg[scan_reg];
        cmp_idx_reg <= scan_reg;
        if (better)
        begin
            best_idx_reg   <= cmp_idx_reg;
            best_id_reg    <= rd_id_reg;
            best_burst_reg <= rd_burst_reg;
        end
        if (emit)
        begin
            rsp_status_reg <= emit_status;
            rsp_id_reg     <= emit_id;
            rsp_burst_reg  <= emit_burst;
            rsp_start_reg  <= emit_start;
            rsp_finish_reg <= emit_finish;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign picked_id    = rsp_id_reg;
    assign picked_burst = rsp_burst_reg;
    assign start_time   = rsp_start_reg;
    assign finish_time  = rsp_finish_reg;

    `SJFD_ASSERT_NOW(a_count_matches, clk, rst_n, 1'b1, count_reg == CW'($countones(valid_reg)))
    `SJFD_ASSERT_NOW(a_commit_found, clk, rst_n, state_reg == S_COMMIT, found_reg && valid_reg[best_idx_reg])
    `SJFD_ASSERT_NOW(a_write_free_slot, clk, rst_n, mem_we, !valid_reg[scan_reg])
    `SJFD_ASSERT_NEXT(a_clock_monotonic, clk, rst_n, 1'b1, clock_reg >= $past(clock_reg))

endmodule
